@@ hdl/dcw_pkg.sv @@
// ----------------------------------------------------------------------------
// dcw_pkg
// Shared types and constants for the drive command watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package dcw_pkg;

  localparam int unsigned DriveW   = 8;
  localparam int unsigned SteerW   = 16;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMaxDrive    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSteerMin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSteerMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSteerCenter = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTimeout     = 3'd4;

  // register reset values
  localparam logic [DutyW-1:0]         MaxDriveRst    = 7'd100;
  localparam logic signed [SteerW-1:0] SteerMinRst    = -16'sd4500;
  localparam logic signed [SteerW-1:0] SteerMaxRst    = 16'sd4500;
  localparam logic signed [SteerW-1:0] SteerCenterRst = 16'sd0;
  localparam logic [TicksW-1:0]        TimeoutRst     = 16'd500;

  typedef enum logic [1:0] {
    StatusApplied  = 2'd0,
    StatusRejected = 2'd1,
    StatusTick     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ActNone = 2'd0,
    ActStop = 2'd1,
    ActRun  = 2'd2
  } action_e;

  typedef struct packed {
    logic [DutyW-1:0]         max_drive_pct;
    logic signed [SteerW-1:0] steer_min;
    logic signed [SteerW-1:0] steer_max;
    logic signed [SteerW-1:0] steer_center;
    logic [TicksW-1:0]        timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     func;
    logic signed [DriveW-1:0] drive_pct;
    logic signed [SteerW-1:0] steer_cdeg;
  } cmd_t;

  typedef struct packed {
    status_e                  status;
    action_e                  motor_action;
    logic                     reverse;
    logic [DutyW-1:0]         duty_pct;
    logic                     steer_update;
    logic signed [SteerW-1:0] steer_out;
    logic                     idle;
    logic                     expired;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/dcw_core.sv @@
// ----------------------------------------------------------------------------
// dcw_core
// Applied drive/steer state, watchdog counter and per-transaction decision.
// ----------------------------------------------------------------------------
`default_nettype none

module dcw_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire dcw_pkg::cfg_t cfg_i,
  input  wire dcw_pkg::cmd_t cmd_i,
  output dcw_pkg::res_t      res_o
);

  logic signed [dcw_pkg::DriveW-1:0] applied_drive_q, applied_drive_d;
  logic signed [dcw_pkg::SteerW-1:0] applied_steer_q, applied_steer_d;
  logic [dcw_pkg::TicksW-1:0]        elapsed_q, elapsed_d;
  logic                              disarmed_q, disarmed_d;
  logic                              idle_q, idle_d;

  logic [dcw_pkg::DriveW-1:0] mag;
  logic                       reject;
  logic [dcw_pkg::TicksW-1:0] elapsed_inc;
  logic                       expire;

  assign mag = cmd_i.drive_pct[dcw_pkg::DriveW-1]
             ? (~cmd_i.drive_pct + 8'd1) : cmd_i.drive_pct;

  assign reject = (mag > {1'b0, cfg_i.max_drive_pct})
               || (cmd_i.steer_cdeg < cfg_i.steer_min)
               || (cmd_i.steer_cdeg > cfg_i.steer_max);

  // saturating tick count
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 16'd1;
  assign expire      = !disarmed_q && (elapsed_inc >= cfg_i.timeout_ticks);

  always_comb begin
    applied_drive_d = applied_drive_q;
    applied_steer_d = applied_steer_q;
    elapsed_d       = elapsed_q;
    disarmed_d      = disarmed_q;
    idle_d          = idle_q;

    res_o              = '0;
    res_o.status       = dcw_pkg::StatusTick;
    res_o.motor_action = dcw_pkg::ActNone;

    if (!cmd_i.func) begin
      if (reject) begin
        res_o.status = dcw_pkg::StatusRejected;
      end else begin
        res_o.status = dcw_pkg::StatusApplied;
        idle_d       = (cmd_i.drive_pct == '0);
        if (cmd_i.drive_pct == '0) begin
          if (applied_drive_q != '0) begin
            res_o.motor_action = dcw_pkg::ActStop;
          end
        end else if (cmd_i.drive_pct != applied_drive_q) begin
          res_o.motor_action = dcw_pkg::ActRun;
          res_o.reverse      = !cmd_i.drive_pct[dcw_pkg::DriveW-1];
          res_o.duty_pct     = mag[dcw_pkg::DutyW-1:0];
        end
        if (cmd_i.steer_cdeg != applied_steer_q) begin
          res_o.steer_update = 1'b1;
          res_o.steer_out    = cmd_i.steer_cdeg;
        end
        applied_drive_d = cmd_i.drive_pct;
        applied_steer_d = cmd_i.steer_cdeg;
        elapsed_d       = '0;
        disarmed_d      = 1'b0;
      end
    end else if (!disarmed_q) begin
      elapsed_d = elapsed_inc;
      if (expire) begin
        res_o.motor_action = dcw_pkg::ActStop;
        res_o.steer_update = 1'b1;
        res_o.steer_out    = cfg_i.steer_center;
        res_o.expired      = 1'b1;
        applied_drive_d    = '0;
        applied_steer_d    = cfg_i.steer_center;
        idle_d             = 1'b1;
        disarmed_d         = 1'b1;
      end
    end

    res_o.idle = idle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_drive_q <= '0;
      applied_steer_q <= dcw_pkg::SteerCenterRst;
      elapsed_q       <= '0;
      disarmed_q      <= 1'b1;
      idle_q          <= 1'b1;
    end else if (advance_i) begin
      applied_drive_q <= applied_drive_d;
      applied_steer_q <= applied_steer_d;
      elapsed_q       <= elapsed_d;
      disarmed_q      <= disarmed_d;
      idle_q          <= idle_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/drive_command_watchdog.sv @@
// ----------------------------------------------------------------------------
// drive_command_watchdog
// Path: an input transaction is captured in the input register at the accepting
//   edge and moves on to the result register when that register frees up.
// Throughput: 1 transaction per cycle unless a stalled result holds advance.
// Reset: async active low; limits back to defaults, drive idle, watchdog off.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_watchdog (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dcw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dcw_pkg::CfgDataW-1:0]        cfg_data_i,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                func_i,
  input  wire logic signed [dcw_pkg::DriveW-1:0]   drive_pct_i,
  input  wire logic signed [dcw_pkg::SteerW-1:0]   steer_cdeg_i,
  // results
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [1:0]                               status_o,
  output logic [1:0]                               motor_action_o,
  output logic                                     reverse_o,
  output logic [dcw_pkg::DutyW-1:0]                duty_pct_o,
  output logic                                     steer_update_o,
  output logic signed [dcw_pkg::SteerW-1:0]        steer_out_o,
  output logic                                     idle_o,
  output logic                                     expired_o
);

  dcw_pkg::cfg_t cfg_q;
  dcw_pkg::cmd_t cmd_q;
  logic          cmd_valid_q;
  dcw_pkg::res_t res_d, res_q;
  logic          out_valid_q;
  logic          advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_drive_pct <= dcw_pkg::MaxDriveRst;
      cfg_q.steer_min     <= dcw_pkg::SteerMinRst;
      cfg_q.steer_max     <= dcw_pkg::SteerMaxRst;
      cfg_q.steer_center  <= dcw_pkg::SteerCenterRst;
      cfg_q.timeout_ticks <= dcw_pkg::TimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dcw_pkg::RegMaxDrive:    cfg_q.max_drive_pct <= cfg_data_i[dcw_pkg::DutyW-1:0];
        dcw_pkg::RegSteerMin:    cfg_q.steer_min     <= cfg_data_i;
        dcw_pkg::RegSteerMax:    cfg_q.steer_max     <= cfg_data_i;
        dcw_pkg::RegSteerCenter: cfg_q.steer_center  <= cfg_data_i;
        dcw_pkg::RegTimeout:     cfg_q.timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage moves on when the result register is free or being drained
  assign advance    = cmd_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !cmd_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      cmd_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.func       <= func_i;
      cmd_q.drive_pct  <= drive_pct_i;
      cmd_q.steer_cdeg <= steer_cdeg_i;
    end
  end

  dcw_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign motor_action_o = res_q.motor_action;
  assign reverse_o      = res_q.reverse;
  assign duty_pct_o     = res_q.duty_pct;
  assign steer_update_o = res_q.steer_update;
  assign steer_out_o    = res_q.steer_out;
  assign idle_o         = res_q.idle;
  assign expired_o      = res_q.expired;

endmodule

`default_nettype wire

@@ hdl/dcw_checker.sv @@
// ----------------------------------------------------------------------------
// dcw_checker
// Port-level checks on the drive command watchdog results.
// ----------------------------------------------------------------------------
`default_nettype none

module dcw_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [1:0]                        status_o,
  input wire logic [1:0]                        motor_action_o,
  input wire logic                              reverse_o,
  input wire logic [dcw_pkg::DutyW-1:0]         duty_pct_o,
  input wire logic                              steer_update_o,
  input wire logic signed [dcw_pkg::SteerW-1:0] steer_out_o,
  input wire logic                              idle_o,
  input wire logic                              expired_o
);

  // a watchdog expiry is a tick that stops, recenters and idles
  a_expire_safe_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_o |-> status_o == dcw_pkg::StatusTick
      && motor_action_o == dcw_pkg::ActStop && steer_update_o && idle_o)
    else $error("expiry without full safe stop");

  // rejected command has no side effects on the outputs
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dcw_pkg::StatusRejected |-> motor_action_o == dcw_pkg::ActNone
      && !steer_update_o && !expired_o && !reverse_o && duty_pct_o == '0 && steer_out_o == '0)
    else $error("rejected command produced an action");

  // run action means nonzero duty and not idle
  a_run_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_action_o == dcw_pkg::ActRun |-> duty_pct_o != '0 && !idle_o
      && status_o == dcw_pkg::StatusApplied)
    else $error("run action with zero duty or idle");

  // stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(steer_out_o) && $stable(motor_action_o))
    else $error("stalled result changed");

endmodule

bind drive_command_watchdog dcw_checker u_dcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .motor_action_o (motor_action_o),
  .reverse_o      (reverse_o),
  .duty_pct_o     (duty_pct_o),
  .steer_update_o (steer_update_o),
  .steer_out_o    (steer_out_o),
  .idle_o         (idle_o),
  .expired_o      (expired_o)
);

`default_nettype wire

@@ test/drive_command_watchdog_test.sv @@
// ----------------------------------------------------------------------------
// drive_command_watchdog_test
// Self-checking bench for the drive command watchdog. A queue of commands and
// ticks feeds a valid/ready driver; a monitor compares each result against an
// in-bench model of limits, change detection, elapsed counting and safe stop.
// Directed cases cover limits and expiry; random phases then cycle through
// register settings under varying backpressure, ending with a longer
// timeout run.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_watchdog_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DriveW   = dcw_pkg::DriveW;
  localparam int unsigned SteerW   = dcw_pkg::SteerW;
  localparam int unsigned DutyW    = dcw_pkg::DutyW;
  localparam int unsigned TicksW   = dcw_pkg::TicksW;
  localparam int unsigned CfgIdxW  = dcw_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = dcw_pkg::CfgDataW;

  localparam int CycleLimit = 1_000_000;
  localparam int PrintCap   = 50;
  localparam int PhaseItems = 140;
  localparam int RandPhases = 12;
  localparam int LongTmo    = 100;
  localparam logic FuncCmd  = 1'b0;
  localparam logic FuncTick = 1'b1;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = dcw_pkg::RegTimeout + 3'd1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [CfgDataW-1:0]      cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     func      = 1'b0;
  logic signed [DriveW-1:0] drive_pct = '0;
  logic signed [SteerW-1:0] steer_cdeg = '0;
  logic                     out_ready = 1'b0;

  wire logic                     cfg_ready_o;
  wire logic                     in_ready_o;
  wire logic                     out_valid_o;
  wire logic [1:0]               status_o;
  wire logic [1:0]               motor_action_o;
  wire logic                     reverse_o;
  wire logic [DutyW-1:0]         duty_pct_o;
  wire logic                     steer_update_o;
  wire logic signed [SteerW-1:0] steer_out_o;
  wire logic                     idle_o;
  wire logic                     expired_o;

  drive_command_watchdog dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .func_i         (func),
    .drive_pct_i    (drive_pct),
    .steer_cdeg_i   (steer_cdeg),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .motor_action_o (motor_action_o),
    .reverse_o      (reverse_o),
    .duty_pct_o     (duty_pct_o),
    .steer_update_o (steer_update_o),
    .steer_out_o    (steer_out_o),
    .idle_o         (idle_o),
    .expired_o      (expired_o)
  );

  always #6 clk = ~clk;

  // model copy of the limit registers
  logic [DutyW-1:0]         lim_max_drive = dcw_pkg::MaxDriveRst;
  logic signed [SteerW-1:0] lim_steer_min = dcw_pkg::SteerMinRst;
  logic signed [SteerW-1:0] lim_steer_max = dcw_pkg::SteerMaxRst;
  logic signed [SteerW-1:0] lim_center    = dcw_pkg::SteerCenterRst;
  logic [TicksW-1:0]        lim_timeout   = dcw_pkg::TimeoutRst;

  // model copy of the applied actuator state and watchdog
  logic signed [DriveW-1:0] act_drive    = '0;
  logic signed [SteerW-1:0] act_steer    = dcw_pkg::SteerCenterRst;
  logic [TicksW-1:0]        wd_elapsed   = '0;
  logic                     wd_disarmed  = 1'b1;
  logic                     drive_idle   = 1'b1;

  dcw_pkg::cmd_t cmd_backlog[$];
  dcw_pkg::res_t due_results[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic in_fire      = 1'b0;
  int  n_pushed      = 0;
  int  n_accepted    = 0;
  int  n_results     = 0;
  int  n_rejected    = 0;
  int  n_expiries    = 0;
  int  n_reg_writes  = 0;
  int  n_settings    = 0;
  int  n_errors      = 0;
  int  cycles        = 0;

  function automatic dcw_pkg::res_t watchdog_outcome(dcw_pkg::cmd_t c);
    dcw_pkg::res_t r;
    int            mag;
    r = '0;
    if (c.func == FuncCmd) begin
      mag = (c.drive_pct < 0) ? -int'(c.drive_pct) : int'(c.drive_pct);
      if (mag > int'(lim_max_drive) || c.steer_cdeg < lim_steer_min ||
          c.steer_cdeg > lim_steer_max) begin
        r.status = dcw_pkg::StatusRejected;
      end else begin
        r.status   = dcw_pkg::StatusApplied;
        drive_idle = (c.drive_pct == 0);
        if (c.drive_pct == 0) begin
          if (act_drive != 0) r.motor_action = dcw_pkg::ActStop;
        end else if (c.drive_pct != act_drive) begin
          r.motor_action = dcw_pkg::ActRun;
          r.reverse      = (c.drive_pct > 0);
          r.duty_pct     = DutyW'(mag);
        end
        if (c.steer_cdeg != act_steer) begin
          r.steer_update = 1'b1;
          r.steer_out    = c.steer_cdeg;
        end
        act_drive   = c.drive_pct;
        act_steer   = c.steer_cdeg;
        wd_elapsed  = '0;
        wd_disarmed = 1'b0;
      end
    end else begin
      r.status = dcw_pkg::StatusTick;
      if (!wd_disarmed) begin
        if (wd_elapsed != '1) wd_elapsed++;
        if (wd_elapsed >= lim_timeout) begin
          // safe stop: motor off, servo back to centre, watchdog off
          r.motor_action = dcw_pkg::ActStop;
          r.steer_update = 1'b1;
          r.steer_out    = lim_center;
          r.expired      = 1'b1;
          act_drive      = '0;
          act_steer      = lim_center;
          drive_idle     = 1'b1;
          wd_disarmed    = 1'b1;
        end
      end
    end
    r.idle = drive_idle;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (n_errors < PrintCap) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_error($sformatf("result %0d %s: got %0d, want %0d", n_results, name, got, want));
    end
  endtask

  // input acceptance and prediction, result checking
  always @(posedge clk) begin : sample_side
    dcw_pkg::res_t want;
    in_fire = in_valid && in_ready_o;
    if (in_fire) begin
      want = watchdog_outcome('{func: func, drive_pct: drive_pct, steer_cdeg: steer_cdeg});
      if (want.status == dcw_pkg::StatusRejected) n_rejected++;
      if (want.expired) n_expiries++;
      due_results.push_back(want);
      n_accepted++;
    end
    if (rst_n && out_valid_o && out_ready) begin
      n_results++;
      if (due_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing due", n_results));
      end else begin
        want = due_results.pop_front();
        check_field("status", status_o, want.status);
        check_field("motor_action", motor_action_o, want.motor_action);
        check_field("reverse", reverse_o, want.reverse);
        check_field("duty_pct", duty_pct_o, want.duty_pct);
        check_field("steer_update", steer_update_o, want.steer_update);
        check_field("steer_out", int'(steer_out_o), int'(want.steer_out));
        check_field("idle", idle_o, want.idle);
        check_field("expired", expired_o, want.expired);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("run exceeded %0d cycles with %0d results outstanding",
               CycleLimit, due_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // input driver and result backpressure
  always @(negedge clk) begin : drive_side
    dcw_pkg::cmd_t nxt;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          in_valid   <= 1'b1;
          func       <= nxt.func;
          drive_pct  <= nxt.drive_pct;
          steer_cdeg <= nxt.steer_cdeg;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_item(logic f, logic signed [DriveW-1:0] d, logic signed [SteerW-1:0] s);
    cmd_backlog.push_back('{func: f, drive_pct: d, steer_cdeg: s});
    n_pushed++;
  endtask

  task automatic push_tick();
    push_item(FuncTick, DriveW'($urandom), SteerW'($urandom));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      dcw_pkg::RegMaxDrive:    lim_max_drive = data[DutyW-1:0];
      dcw_pkg::RegSteerMin:    lim_steer_min = data;
      dcw_pkg::RegSteerMax:    lim_steer_max = data;
      dcw_pkg::RegSteerCenter: lim_center    = data;
      dcw_pkg::RegTimeout:     lim_timeout   = data;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic end_reg_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // block is idle once every queued transaction is in and every result is out
  task automatic wait_quiet();
    do @(negedge clk); while (n_accepted != n_pushed || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_pressure(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic pick_settings();
    int md, lo, hi, ctr, tmo;
    case ($urandom_range(0, 3))
      0: md = 0;
      1: md = 127;
      2: md = 100;
      default: md = $urandom_range(0, 127);
    endcase
    case ($urandom_range(0, 5))
      0: begin lo = -32768; hi = 32767; end
      1: begin lo = int'($urandom_range(1, 3000)); hi = -int'($urandom_range(0, 3000)); end
      2: begin lo = int'($urandom_range(0, 65535)) - 32768; hi = lo; end
      default: begin lo = -int'($urandom_range(0, 6000)); hi = int'($urandom_range(0, 6000)); end
    endcase
    if (lo <= hi && $urandom_range(0, 2) != 0) ctr = lo + int'($urandom_range(0, hi - lo));
    else ctr = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 7))
      0: tmo = 0;
      1: tmo = 65535;
      2: tmo = $urandom_range(41, 300);
      default: tmo = $urandom_range(1, 30);
    endcase
    // upper data bits are don't-care for the 7-bit drive limit
    write_reg(dcw_pkg::RegMaxDrive, (CfgDataW'($urandom) & 16'hFF80) | CfgDataW'(md));
    write_reg(dcw_pkg::RegSteerMin, CfgDataW'(lo));
    write_reg(dcw_pkg::RegSteerMax, CfgDataW'(hi));
    write_reg(dcw_pkg::RegSteerCenter, CfgDataW'(ctr));
    write_reg(dcw_pkg::RegTimeout, CfgDataW'(tmo));
    write_reg(RegUnusedLo + CfgIdxW'($urandom_range(0, 2)), CfgDataW'($urandom));
    end_reg_writes();
  endtask

  task automatic gen_random_items(int n);
    int start, m, lo, hi, mag, len, k;
    logic signed [DriveW-1:0] d, last_d;
    logic signed [SteerW-1:0] s, last_s;
    start  = n_pushed;
    m      = int'(lim_max_drive);
    lo     = int'(lim_steer_min);
    hi     = int'(lim_steer_max);
    last_d = act_drive;
    last_s = act_steer;
    while (n_pushed - start < n) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        push_item(1'($urandom), DriveW'($urandom), SteerW'($urandom));
      end else if (k < 50) begin
        // in-limit command, often repeating the last one to hit change detection
        case ($urandom_range(0, 3))
          0: d = '0;
          1: d = last_d;
          default: d = DriveW'(int'($urandom_range(0, 2 * m)) - m);
        endcase
        case ($urandom_range(0, 4))
          0, 1: s = last_s;
          2: s = lim_center;
          default: s = (lo <= hi) ? SteerW'(lo + int'($urandom_range(0, hi - lo)))
                                  : SteerW'($urandom);
        endcase
        last_d = d;
        last_s = s;
        push_item(FuncCmd, d, s);
      end else if (k < 55) begin
        mag = $urandom_range(m + 1, 128);
        d = (mag == 128 || $urandom_range(0, 1) != 0) ? DriveW'(-mag) : DriveW'(mag);
        push_item(FuncCmd, d, SteerW'($urandom));
      end else if (k < 80) begin
        push_tick();
      end else begin
        // tick burst sized to run the watchdog out when the timeout is 40 or less
        len = (lim_timeout <= 40) ? int'(lim_timeout) + $urandom_range(0, 3)
                                  : $urandom_range(1, 40);
        repeat (len) push_tick();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset limits
    set_pressure(11, 65);
    push_tick();                        // disarmed tick
    push_item(FuncCmd, 8'sd0, 16'sd0);
    push_item(FuncCmd, 8'sd100, 16'sd4500);
    push_item(FuncCmd, 8'sd100, 16'sd4500);
    push_item(FuncCmd, -8'sd100, -16'sd4500);
    push_item(FuncCmd, 8'sd101, 16'sd0);
    push_item(FuncCmd, -8'sd128, 16'sd0);
    push_item(FuncCmd, 8'sd127, 16'sd0);
    push_item(FuncCmd, 8'sd0, 16'sd4501);
    push_item(FuncCmd, 8'sd0, -16'sd4501);
    push_item(FuncCmd, 8'sd0, 16'sd32767);
    push_item(FuncCmd, 8'sd0, -16'sd32768);
    push_item(FuncCmd, 8'sd0, -16'sd4500);
    push_tick();
    wait_quiet();

    // widest limits, zero timeout
    write_reg(dcw_pkg::RegMaxDrive, 16'hFFFF);
    write_reg(dcw_pkg::RegSteerMin, 16'h8000);
    write_reg(dcw_pkg::RegSteerMax, 16'h7FFF);
    write_reg(dcw_pkg::RegSteerCenter, 16'h8000);
    write_reg(dcw_pkg::RegTimeout, 16'h0000);
    write_reg(RegUnusedLo, 16'hFFFF);
    end_reg_writes();
    push_tick();                        // expires at once
    push_tick();
    push_item(FuncCmd, 8'sd127, 16'sd32767);
    push_item(FuncCmd, -8'sd128, 16'sd0);
    push_item(FuncCmd, -8'sd127, -16'sd32768);
    push_tick();
    wait_quiet();

    // new centre only takes effect at the next safe stop
    write_reg(dcw_pkg::RegSteerCenter, 16'd1234);
    end_reg_writes();
    push_item(FuncCmd, 8'sd0, -16'sd32768);
    push_tick();
    wait_quiet();

    // inverted steering window rejects everything
    write_reg(dcw_pkg::RegSteerMin, 16'd100);
    write_reg(dcw_pkg::RegSteerMax, -16'sd100);
    write_reg(dcw_pkg::RegMaxDrive, 16'd0);
    end_reg_writes();
    push_item(FuncCmd, 8'sd0, 16'sd0);
    push_tick();
    wait_quiet();

    write_reg(dcw_pkg::RegSteerMin, -16'sd100);
    write_reg(dcw_pkg::RegSteerMax, 16'sd100);
    end_reg_writes();
    push_item(FuncCmd, 8'sd0, 16'sd0);
    push_item(FuncCmd, 8'sd1, 16'sd0);
    push_item(FuncCmd, -8'sd1, 16'sd100);
    wait_quiet();

    for (int p = 0; p < RandPhases; p++) begin
      case (p * 3 / RandPhases)
        0: set_pressure(11, 65);
        1: set_pressure(65, 11);
        default: set_pressure(0, 0);
      endcase
      pick_settings();
      gen_random_items(PhaseItems);
      wait_quiet();
    end

    // longer timeout: counter runs up to the limit, then one disarmed tick
    set_pressure(0, 0);
    write_reg(dcw_pkg::RegMaxDrive, 16'd100);
    write_reg(dcw_pkg::RegSteerMin, -16'sd4500);
    write_reg(dcw_pkg::RegSteerMax, 16'sd4500);
    write_reg(dcw_pkg::RegSteerCenter, 16'sd250);
    write_reg(dcw_pkg::RegTimeout, CfgDataW'(LongTmo));
    end_reg_writes();
    push_item(FuncCmd, 8'sd30, 16'sd0);
    repeat (LongTmo + 1) push_tick();
    wait_quiet();
    repeat (8) @(negedge clk);

    $display("Checked %0d results from %0d transactions: %0d rejected, %0d watchdog expiries.",
             n_results, n_accepted, n_rejected, n_expiries);
    $display("Register settings: %0d, %0d register writes, %0d mismatches.",
             n_settings, n_reg_writes, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/dcw_pkg.sv
hdl/dcw_core.sv
hdl/drive_command_watchdog.sv
hdl/dcw_checker.sv
test/drive_command_watchdog_test.sv
